>>> rtl/jsv_pkg.sv
`default_nettype none

package jsv_pkg;

  // Default nesting limit of the container stack
  localparam int unsigned MAX_DEPTH_DEF = 32;

  // Verdict and error codes (error register uses the same codes)
  localparam logic [1:0] VERDICT_OK     = 2'd0;
  localparam logic [1:0] VERDICT_SYNTAX = 2'd1;
  localparam logic [1:0] VERDICT_DEPTH  = 2'd2;

  // Parser phases
  typedef enum logic [4:0] {
    PH_VALUE     = 5'd0,
    PH_ARR_FIRST = 5'd1,
    PH_OBJ_FIRST = 5'd2,
    PH_OBJ_KEY   = 5'd3,
    PH_COLON     = 5'd4,
    PH_AFTER     = 5'd5,
    PH_STR       = 5'd6,
    PH_STR_ESC   = 5'd7,
    PH_STR_HEX   = 5'd8,
    PH_KEY       = 5'd9,
    PH_KEY_ESC   = 5'd10,
    PH_KEY_HEX   = 5'd11,
    PH_TRUE      = 5'd12,
    PH_FALSE     = 5'd13,
    PH_NULL      = 5'd14,
    PH_MINUS     = 5'd15,
    PH_INT       = 5'd16,
    PH_FRAC0     = 5'd17,
    PH_FRAC      = 5'd18,
    PH_EXP0      = 5'd19,
    PH_EXPS      = 5'd20,
    PH_EXP       = 5'd21
  } phase_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == " ") || (c == "\t") || (c == "\r") || (c == "\n");
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'd48) && (c <= 8'd57);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return ((c >= 8'd48) && (c <= 8'd57)) || ((c >= 8'd65) && (c <= 8'd70)) ||
           ((c >= 8'd97) && (c <= 8'd102));
  endfunction

  function automatic logic is_delim(input logic [7:0] c);
    return (c == "}") || (c == "]") || (c == ",") || is_ws(c);
  endfunction

  // Length of the keyword tracked by a literal phase
  function automatic logic [2:0] lit_len(input phase_t ph);
    logic [2:0] len;
    case (ph)
      PH_FALSE: len = 3'd5;
      default:  len = 3'd4;
    endcase
    return len;
  endfunction

  // Expected character at a position of the keyword
  function automatic logic [7:0] lit_char(input phase_t ph, input logic [2:0] idx);
    logic [7:0] ch;
    ch = 8'd0;
    case (ph)
      PH_TRUE: begin
        case (idx)
          3'd0:    ch = "t";
          3'd1:    ch = "r";
          3'd2:    ch = "u";
          3'd3:    ch = "e";
          default: ch = 8'd0;
        endcase
      end
      PH_FALSE: begin
        case (idx)
          3'd0:    ch = "f";
          3'd1:    ch = "a";
          3'd2:    ch = "l";
          3'd3:    ch = "s";
          3'd4:    ch = "e";
          default: ch = 8'd0;
        endcase
      end
      PH_NULL: begin
        case (idx)
          3'd0:    ch = "n";
          3'd1:    ch = "u";
          3'd2:    ch = "l";
          3'd3:    ch = "l";
          default: ch = 8'd0;
        endcase
      end
      default: ch = 8'd0;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

>>> rtl/json_syntax_validator.sv
// Streaming JSON syntax checker, one text byte per request. Throughput: one
// byte per cycle unless a held verdict stalls; parser state and stack top
// update in a single pass between the input register and the state registers.
// The verdict is registered as the last byte leaves the input register; a
// held verdict stalls only the next last byte. Reset (rst_n low, synchronous)
// clears parser, level, error and both valid flags, not the stack memory.
`default_nettype none

module json_syntax_validator #(
  parameter int unsigned MAX_DEPTH = jsv_pkg::MAX_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] text_byte
  input  wire logic       in_tlast,   // is_last
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata   // [1:0] verdict, [7:2] zero
);

  import jsv_pkg::*;

  localparam int unsigned LVL_W = $clog2(MAX_DEPTH + 1);
  localparam int unsigned IDX_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  // Input register
  logic       in_vld_r;
  logic [7:0] byte_r;
  logic       last_r;

  // Parser state
  phase_t           phase_r, phase_nxt;
  logic [LVL_W-1:0] level_r, level_nxt;
  logic [2:0]       sub_r, sub_nxt;
  logic [1:0]       err_r, err_nxt;

  // Stack: top and next-below entries in flops, the rest in memory
  logic             top_r;
  logic             below_r;
  logic             stk_mem [MAX_DEPTH];
  logic [LVL_W-1:0] lvl_m1;
  logic [LVL_W-1:0] lvl_m3;

  // Output register
  logic       out_vld_r;
  logic [1:0] verdict_r;
  logic [1:0] verdict_nxt;

  logic fire;
  logic consume;
  logic full;
  logic push_fire;
  logic pop_fire;

  // After-value decode
  phase_t av_phase;
  logic   av_fail;
  logic   av_pop;

  // Value-start decode
  phase_t sv_phase;
  logic   sv_fail;
  logic   sv_push;
  logic   sv_obj;

  // Per-byte events
  phase_t     ph_n;
  logic [2:0] sub_n;
  logic       ev_fail;
  logic       ev_push;
  logic       ev_obj;
  logic       ev_pop;

  logic [7:0] c;

  // Stall only when a last byte waits for a busy result slot
  assign fire      = in_vld_r && !(last_r && out_vld_r && !out_tready);
  assign in_tready = !in_vld_r || fire;
  assign consume   = fire && (err_r == VERDICT_OK);
  assign full      = (level_r >= LVL_W'(MAX_DEPTH));
  assign push_fire = consume && ev_push && !full;
  assign pop_fire  = consume && ev_pop;
  assign lvl_m1    = level_r - LVL_W'(1);
  assign lvl_m3    = level_r - LVL_W'(3);
  assign c         = byte_r;

  // Capture input requests
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      byte_r <= in_tdata;
      last_r <= in_tlast;
    end
  end

  // Decode a byte that follows a complete value
  always_comb begin
    av_phase = PH_AFTER;
    av_fail  = 1'b0;
    av_pop   = 1'b0;
    if (!is_ws(c)) begin
      if (level_r == '0) begin
        av_fail = 1'b1;
      end else if (top_r) begin
        if (c == ",") av_phase = PH_OBJ_KEY;
        else if (c == "}") av_pop = 1'b1;
        else av_fail = 1'b1;
      end else begin
        if (c == ",") av_phase = PH_VALUE;
        else if (c == "]") av_pop = 1'b1;
        else av_fail = 1'b1;
      end
    end
  end

  // Decode the first byte of a value
  always_comb begin
    sv_phase = phase_r;
    sv_fail  = 1'b0;
    sv_push  = 1'b0;
    sv_obj   = 1'b0;
    if (c == "\"") sv_phase = PH_STR;
    else if (c == "[") begin
      sv_push  = 1'b1;
      sv_phase = PH_ARR_FIRST;
    end else if (c == "{") begin
      sv_push  = 1'b1;
      sv_obj   = 1'b1;
      sv_phase = PH_OBJ_FIRST;
    end
    else if (c == "t") sv_phase = PH_TRUE;
    else if (c == "f") sv_phase = PH_FALSE;
    else if (c == "n") sv_phase = PH_NULL;
    else if (c == "-") sv_phase = PH_MINUS;
    else if (is_digit(c)) sv_phase = PH_INT;
    else sv_fail = 1'b1;
  end

  // Main phase decode
  always_comb begin
    ph_n    = phase_r;
    sub_n   = sub_r;
    ev_fail = 1'b0;
    ev_push = 1'b0;
    ev_obj  = 1'b0;
    ev_pop  = 1'b0;
    case (phase_r)
      PH_VALUE: begin
        if (!is_ws(c)) begin
          ph_n    = sv_phase;
          sub_n   = 3'd1;
          ev_fail = sv_fail;
          ev_push = sv_push;
          ev_obj  = sv_obj;
        end
      end
      PH_ARR_FIRST: begin
        if (!is_ws(c)) begin
          if (c == "]") begin
            ev_pop = 1'b1;
          end else begin
            ph_n    = sv_phase;
            sub_n   = 3'd1;
            ev_fail = sv_fail;
            ev_push = sv_push;
            ev_obj  = sv_obj;
          end
        end
      end
      PH_OBJ_FIRST: begin
        if (!is_ws(c)) begin
          if (c == "}") ev_pop = 1'b1;
          else if (c == "\"") ph_n = PH_KEY;
          else ev_fail = 1'b1;
        end
      end
      PH_OBJ_KEY: begin
        if (!is_ws(c)) begin
          if (c == "\"") ph_n = PH_KEY;
          else ev_fail = 1'b1;
        end
      end
      PH_COLON: begin
        if (!is_ws(c)) begin
          if (c == ":") ph_n = PH_VALUE;
          else ev_fail = 1'b1;
        end
      end
      PH_AFTER: begin
        ph_n    = av_phase;
        ev_fail = av_fail;
        ev_pop  = av_pop;
      end
      PH_STR: begin
        if (c == "\"") ph_n = PH_AFTER;
        else if (c == "\\") ph_n = PH_STR_ESC;
      end
      PH_STR_ESC: begin
        if (c == "u") begin
          sub_n = 3'd0;
          ph_n  = PH_STR_HEX;
        end else begin
          ph_n = PH_STR;
        end
      end
      PH_STR_HEX: begin
        if (!is_hex(c)) begin
          ev_fail = 1'b1;
        end else begin
          sub_n = sub_r + 3'd1;
          if (sub_r >= 3'd3) ph_n = PH_STR;
        end
      end
      PH_KEY: begin
        if (c == "\"") ph_n = PH_COLON;
        else if (c == "\\") ph_n = PH_KEY_ESC;
      end
      PH_KEY_ESC: begin
        if (c == "u") begin
          sub_n = 3'd0;
          ph_n  = PH_KEY_HEX;
        end else begin
          ph_n = PH_KEY;
        end
      end
      PH_KEY_HEX: begin
        if (!is_hex(c)) begin
          ev_fail = 1'b1;
        end else begin
          sub_n = sub_r + 3'd1;
          if (sub_r >= 3'd3) ph_n = PH_KEY;
        end
      end
      PH_TRUE, PH_FALSE, PH_NULL: begin
        if ((sub_r >= lit_len(phase_r)) || (c != lit_char(phase_r, sub_r))) begin
          ev_fail = 1'b1;
        end else begin
          sub_n = sub_r + 3'd1;
          if ((sub_r + 3'd1) == lit_len(phase_r)) ph_n = PH_AFTER;
        end
      end
      PH_MINUS: begin
        if (is_digit(c)) ph_n = PH_INT;
        else ev_fail = 1'b1;
      end
      PH_INT: begin
        if (!is_digit(c)) begin
          if (c == ".") ph_n = PH_FRAC0;
          else if ((c == "e") || (c == "E")) ph_n = PH_EXP0;
          else if (is_delim(c)) begin
            ph_n    = av_phase;
            ev_fail = av_fail;
            ev_pop  = av_pop;
          end
          else ev_fail = 1'b1;
        end
      end
      PH_FRAC0: begin
        if (is_digit(c)) ph_n = PH_FRAC;
        else ev_fail = 1'b1;
      end
      PH_FRAC: begin
        if (!is_digit(c)) begin
          if ((c == "e") || (c == "E")) ph_n = PH_EXP0;
          else if (is_delim(c)) begin
            ph_n    = av_phase;
            ev_fail = av_fail;
            ev_pop  = av_pop;
          end
          else ev_fail = 1'b1;
        end
      end
      PH_EXP0: begin
        if ((c == "+") || (c == "-")) ph_n = PH_EXPS;
        else if (is_digit(c)) ph_n = PH_EXP;
        else ev_fail = 1'b1;
      end
      PH_EXPS: begin
        if (is_digit(c)) ph_n = PH_EXP;
        else ev_fail = 1'b1;
      end
      PH_EXP: begin
        if (!is_digit(c)) begin
          if (is_delim(c)) begin
            ph_n    = av_phase;
            ev_fail = av_fail;
            ev_pop  = av_pop;
          end else begin
            ev_fail = 1'b1;
          end
        end
      end
      default: ev_fail = 1'b1;
    endcase
  end

  // Apply events to the parser state and form the verdict
  always_comb begin
    phase_nxt = phase_r;
    level_nxt = level_r;
    sub_nxt   = sub_r;
    err_nxt   = err_r;
    if (consume) begin
      sub_nxt = sub_n;
      if (ev_fail) begin
        err_nxt = VERDICT_SYNTAX;
        phase_nxt = ph_n;
      end else if (ev_push && full) begin
        err_nxt = VERDICT_DEPTH;
      end else if (ev_pop) begin
        phase_nxt = PH_AFTER;
        if (level_r != '0) level_nxt = level_r - LVL_W'(1);
      end else begin
        phase_nxt = ph_n;
        if (ev_push) level_nxt = level_r + LVL_W'(1);
      end
    end
    if (err_nxt != VERDICT_OK) begin
      verdict_nxt = err_nxt;
    end else if ((level_nxt == '0) &&
                 ((phase_nxt == PH_AFTER) || (phase_nxt == PH_INT) ||
                  (phase_nxt == PH_FRAC) || (phase_nxt == PH_EXP))) begin
      verdict_nxt = VERDICT_OK;
    end else begin
      verdict_nxt = VERDICT_SYNTAX;
    end
  end

  // Parser registers; the last byte returns them to the idle values
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_VALUE;
      level_r <= '0;
      sub_r   <= 3'd0;
      err_r   <= VERDICT_OK;
    end else if (fire && last_r) begin
      phase_r <= PH_VALUE;
      level_r <= '0;
      sub_r   <= 3'd0;
      err_r   <= VERDICT_OK;
    end else begin
      phase_r <= phase_nxt;
      level_r <= level_nxt;
      sub_r   <= sub_nxt;
      err_r   <= err_nxt;
    end
  end

  // Spill the old top into memory on a push
  always_ff @(posedge clk) begin
    if (push_fire && (level_r != '0)) begin
      stk_mem[lvl_m1[IDX_W-1:0]] <= top_r;
    end
  end

  // Advance top and below entries; a pop refills below from memory
  always_ff @(posedge clk) begin
    if (push_fire) begin
      top_r   <= ev_obj;
      below_r <= top_r;
    end else if (pop_fire) begin
      top_r   <= below_r;
      below_r <= stk_mem[lvl_m3[IDX_W-1:0]];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fire && last_r) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && last_r) begin
      verdict_r <= verdict_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {6'd0, verdict_r};

endmodule

`default_nettype wire

>>> test/json_syntax_validator_check.sv
module json_syntax_validator_check #(
  parameter int unsigned MAX_DEPTH = jsv_pkg::MAX_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] text_byte
  input  logic       in_tlast,   // is_last
  input  logic       out_tvalid,
  input  logic       out_tready,
  input  logic [7:0] out_tdata,  // [1:0] verdict, [7:2] zero
  output int         mismatches,
  output int         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import jsv_pkg::*;

  // Shadow parser state
  phase_t     phase;
  logic       open_obj[MAX_DEPTH];
  int         level;
  int         sub_cnt;
  logic [1:0] err_code;

  // Verdicts owed by the block, oldest first
  logic [1:0] verdict_q[$];
  int         mism = 0;

  assign mismatches = mism;

  function automatic logic blank(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0d) || (c == 8'h0a);
  endfunction

  function automatic logic dec_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic hex_digit(input logic [7:0] c);
    return dec_digit(c) || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
  endfunction

  function automatic logic number_stop(input logic [7:0] c);
    return (c == "}") || (c == "]") || (c == ",") || blank(c);
  endfunction

  function automatic void clear_parser();
    phase    = PH_VALUE;
    level    = 0;
    sub_cnt  = 0;
    err_code = VERDICT_OK;
  endfunction

  // Keep the first error only
  function automatic void mark_syntax();
    if (err_code == VERDICT_OK) err_code = VERDICT_SYNTAX;
  endfunction

  function automatic void open_container(input logic obj);
    if (level >= MAX_DEPTH) begin
      err_code = VERDICT_DEPTH;
      return;
    end
    open_obj[level] = obj;
    level++;
    phase = obj ? PH_OBJ_FIRST : PH_ARR_FIRST;
  endfunction

  function automatic void close_container();
    if (level != 0) level--;
    phase = PH_AFTER;
  endfunction

  function automatic void start_token(input logic [7:0] c);
    sub_cnt = 1;
    case (c)
      "\"":    phase = PH_STR;
      "[":     open_container(1'b0);
      "{":     open_container(1'b1);
      "t":     phase = PH_TRUE;
      "f":     phase = PH_FALSE;
      "n":     phase = PH_NULL;
      "-":     phase = PH_MINUS;
      default: if (dec_digit(c)) phase = PH_INT; else mark_syntax();
    endcase
  endfunction

  // Separator or closer after a complete value
  function automatic void after_token(input logic [7:0] c);
    phase = PH_AFTER;
    if (blank(c)) return;
    if (level == 0) begin
      mark_syntax();
      return;
    end
    if (c == ",") phase = open_obj[level-1] ? PH_OBJ_KEY : PH_VALUE;
    else if (c == (open_obj[level-1] ? "}" : "]")) close_container();
    else mark_syntax();
  endfunction

  function automatic void keyword_step(input logic [7:0] c);
    logic [39:0] word;
    int          len;
    case (phase)
      PH_TRUE: begin
        word = "true";
        len  = 4;
      end
      PH_FALSE: begin
        word = "false";
        len  = 5;
      end
      default: begin
        word = "null";
        len  = 4;
      end
    endcase
    if (sub_cnt >= len || c != word[8*(len-1-sub_cnt) +: 8]) begin
      mark_syntax();
      return;
    end
    sub_cnt++;
    if (sub_cnt == len) phase = PH_AFTER;
  endfunction

  function automatic void number_done(input logic [7:0] c);
    if (number_stop(c)) after_token(c); else mark_syntax();
  endfunction

  // Plain strings and object keys share the escape handling
  function automatic void string_step(input logic [7:0] c);
    logic key;
    key = (phase == PH_KEY) || (phase == PH_KEY_ESC) || (phase == PH_KEY_HEX);
    case (phase)
      PH_STR, PH_KEY: begin
        if (c == "\"") phase = key ? PH_COLON : PH_AFTER;
        else if (c == "\\") phase = key ? PH_KEY_ESC : PH_STR_ESC;
      end
      PH_STR_ESC, PH_KEY_ESC: begin
        if (c == "u") begin
          sub_cnt = 0;
          phase   = key ? PH_KEY_HEX : PH_STR_HEX;
        end else begin
          phase = key ? PH_KEY : PH_STR;
        end
      end
      default: begin
        if (!hex_digit(c)) begin
          mark_syntax();
        end else begin
          sub_cnt++;
          if (sub_cnt >= 4) phase = key ? PH_KEY : PH_STR;
        end
      end
    endcase
  endfunction

  function automatic void take_char(input logic [7:0] c);
    case (phase)
      PH_VALUE: if (!blank(c)) start_token(c);
      PH_ARR_FIRST: if (!blank(c)) begin
        if (c == "]") close_container(); else start_token(c);
      end
      PH_OBJ_FIRST: if (!blank(c)) begin
        if (c == "}") close_container();
        else if (c == "\"") phase = PH_KEY;
        else mark_syntax();
      end
      PH_OBJ_KEY: if (!blank(c)) begin
        if (c == "\"") phase = PH_KEY; else mark_syntax();
      end
      PH_COLON: if (!blank(c)) begin
        if (c == ":") phase = PH_VALUE; else mark_syntax();
      end
      PH_AFTER: after_token(c);
      PH_STR, PH_STR_ESC, PH_STR_HEX, PH_KEY, PH_KEY_ESC, PH_KEY_HEX: string_step(c);
      PH_TRUE, PH_FALSE, PH_NULL: keyword_step(c);
      PH_MINUS: if (dec_digit(c)) phase = PH_INT; else mark_syntax();
      PH_INT: if (!dec_digit(c)) begin
        if (c == ".") phase = PH_FRAC0;
        else if (c == "e" || c == "E") phase = PH_EXP0;
        else number_done(c);
      end
      PH_FRAC0: if (dec_digit(c)) phase = PH_FRAC; else mark_syntax();
      PH_FRAC: if (!dec_digit(c)) begin
        if (c == "e" || c == "E") phase = PH_EXP0; else number_done(c);
      end
      PH_EXP0: begin
        if (c == "+" || c == "-") phase = PH_EXPS;
        else if (dec_digit(c)) phase = PH_EXP;
        else mark_syntax();
      end
      PH_EXPS: if (dec_digit(c)) phase = PH_EXP; else mark_syntax();
      PH_EXP: if (!dec_digit(c)) number_done(c);
      default: mark_syntax();
    endcase
  endfunction

  // A number may end right at the final byte
  function automatic logic [1:0] text_verdict();
    if (err_code != VERDICT_OK) return err_code;
    if (level == 0 && (phase == PH_AFTER || phase == PH_INT || phase == PH_FRAC ||
                       phase == PH_EXP)) return VERDICT_OK;
    return VERDICT_SYNTAX;
  endfunction

  function automatic logic count_mismatch();
    mism++;
    return mism <= 10;
  endfunction

  // Predict on each accepted request, compare each accepted result
  always @(posedge clk) begin
    logic [7:0] want;
    if (!rst_n) begin
      clear_parser();
      verdict_q.delete();
      pending <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        if (err_code == VERDICT_OK) take_char(in_tdata);
        if (in_tlast) begin
          verdict_q.push_back(text_verdict());
          clear_parser();
        end
      end
      if (out_tvalid && out_tready) begin
        if (verdict_q.size() == 0) begin
          if (count_mismatch()) $display("verdict with no text pending: tdata %h", out_tdata);
        end else begin
          want = {6'b0, verdict_q.pop_front()};
          if (out_tdata !== want) begin
            if (count_mismatch())
              $display("verdict mismatch: expected %0d (tdata %h), got tdata %h",
                       want[1:0], want, out_tdata);
          end
        end
      end
      pending <= verdict_q.size();
    end
  end

endmodule

>>> test/json_syntax_validator_test.sv
module json_syntax_validator_test;
  timeunit 1ns;
  timeprecision 1ps;

  import jsv_pkg::*;

  localparam int unsigned DEPTH       = MAX_DEPTH_DEF;
  localparam int          BYTE_TARGET = 1850;
  localparam int          CYCLE_LIMIT = 200000;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = 8'h00;
  logic       in_tlast   = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;

  int         mismatch_count;
  int         verdicts_pending;
  int         cycle_count   = 0;
  logic       in_ready_seen = 1'b0;
  int         hold_left     = 0;
  int         calm_left     = 0;
  int         bytes_sent    = 0;

  // Text under construction and its open containers
  logic [7:0] text_q[$];
  logic       nest_obj[8];
  int         nest_left[8];
  logic       nest_first[8];
  int         nest_n;

  json_syntax_validator #(.MAX_DEPTH(DEPTH)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  json_syntax_validator_check #(.MAX_DEPTH(DEPTH)) u_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .mismatches(mismatch_count),
    .pending   (verdicts_pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Capture ready mid-cycle so the sender sees what the next edge will see
  always @(negedge clk) begin
    in_ready_seen <= in_tready;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Stall the result side, with calm stretches of steady ready
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if (calm_left != 0) calm_left <= calm_left - 1;
      else if ($urandom_range(0, 9) == 0) calm_left <= $urandom_range(50, 300);
      else if ($urandom_range(0, 2) == 0) hold_left <= gap_len();
    end
  end

  function automatic void put_str(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endfunction

  function automatic void put_blank();
    string blanks;
    int    n;
    blanks = " \t\r\n";
    n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 2) : 0;
    repeat (n) text_q.push_back(blanks[$urandom_range(0, 3)]);
  endfunction

  function automatic void put_digits(input int lo, input int hi);
    repeat ($urandom_range(lo, hi)) text_q.push_back(8'($urandom_range(48, 57)));
  endfunction

  // Strings mix plain text, short escapes, unicode escapes and raw bytes
  function automatic void emit_string();
    string      hexs;
    string      escs;
    logic [7:0] c;
    hexs = "0123456789abcdefABCDEF";
    escs = "\"\\/bfnrtx";
    text_q.push_back("\"");
    repeat ($urandom_range(0, 5)) begin
      case ($urandom_range(0, 9))
        0: begin
          text_q.push_back("\\");
          text_q.push_back(escs[$urandom_range(0, 8)]);
        end
        1: begin
          put_str("\\u");
          repeat (4) text_q.push_back(hexs[$urandom_range(0, 21)]);
        end
        2: begin
          if ($urandom_range(0, 1) == 0) text_q.push_back(8'($urandom_range(0, 31)));
          else text_q.push_back(8'($urandom_range(128, 255)));
        end
        default: begin
          c = 8'($urandom_range(32, 126));
          if (c == "\"" || c == "\\") c = "a";
          text_q.push_back(c);
        end
      endcase
    end
    text_q.push_back("\"");
  endfunction

  function automatic void emit_number();
    if ($urandom_range(0, 2) == 0) text_q.push_back("-");
    put_digits(1, 3);
    if ($urandom_range(0, 2) == 0) begin
      text_q.push_back(".");
      put_digits(1, 2);
    end
    if ($urandom_range(0, 2) == 0) begin
      text_q.push_back(($urandom_range(0, 1) == 0) ? "e" : "E");
      case ($urandom_range(0, 2))
        0:       text_q.push_back("+");
        1:       text_q.push_back("-");
        default: ;
      endcase
      put_digits(1, 2);
    end
  endfunction

  // Emit one value; a container is opened here and filled by gen_document
  function automatic void emit_value();
    int kind;
    kind = $urandom_range(0, 7);
    if (nest_n >= 3 && kind < 2) kind += 2;
    case (kind)
      0, 1: begin
        text_q.push_back((kind == 1) ? "{" : "[");
        nest_obj[nest_n]   = (kind == 1);
        nest_left[nest_n]  = $urandom_range(0, 3);
        nest_first[nest_n] = 1'b1;
        nest_n++;
      end
      2, 5: emit_string();
      3, 6: emit_number();
      default: begin
        case ($urandom_range(0, 2))
          0:       put_str("true");
          1:       put_str("false");
          default: put_str("null");
        endcase
      end
    endcase
  endfunction

  function automatic void gen_document();
    nest_n = 0;
    put_blank();
    emit_value();
    while (nest_n != 0) begin
      put_blank();
      if (nest_left[nest_n-1] == 0) begin
        text_q.push_back(nest_obj[nest_n-1] ? "}" : "]");
        nest_n--;
      end else begin
        nest_left[nest_n-1]--;
        if (!nest_first[nest_n-1]) text_q.push_back(",");
        nest_first[nest_n-1] = 1'b0;
        put_blank();
        if (nest_obj[nest_n-1]) begin
          emit_string();
          put_blank();
          text_q.push_back(":");
          put_blank();
        end
        emit_value();
      end
    end
    put_blank();
  endfunction

  // Nest right around the depth limit
  function automatic void gen_deep();
    logic obj[$];
    int   levels;
    levels = $urandom_range(DEPTH - 2, DEPTH + 2);
    for (int i = 0; i < levels; i++) begin
      obj.push_back(1'($urandom_range(0, 1)));
      if (obj[i]) put_str("{\"k\":"); else text_q.push_back("[");
    end
    text_q.push_back("0");
    for (int i = levels - 1; i >= 0; i--) text_q.push_back(obj[i] ? "}" : "]");
  endfunction

  function automatic void gen_noise();
    repeat ($urandom_range(1, 6)) text_q.push_back(8'($urandom_range(0, 255)));
  endfunction

  // Break a well-formed text: overwrite, truncate or insert
  function automatic void corrupt();
    string odd;
    int    at;
    odd = "{}[]\",:\\ tfnue-+.eE0\t";
    at  = $urandom_range(0, text_q.size() - 1);
    case ($urandom_range(0, 3))
      0:       text_q[at] = 8'($urandom_range(0, 255));
      1:       text_q[at] = odd[$urandom_range(0, odd.len() - 1)];
      2:       while (text_q.size() > at + 1) void'(text_q.pop_back());
      default: text_q.insert(at, odd[$urandom_range(0, odd.len() - 1)]);
    endcase
  endfunction

  // Send the built text as requests, last byte flagged
  task automatic send_text();
    int   gap;
    logic calm_text;
    calm_text = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < text_q.size(); i++) begin
      gap = calm_text ? 0 : gap_len();
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_tvalid <= 1'b1;
      in_tdata  <= text_q[i];
      in_tlast  <= (i == text_q.size() - 1);
      @(posedge clk);
      while (!in_ready_seen) @(posedge clk);
    end
    bytes_sent += text_q.size();
    text_q.delete();
  endtask

  // Hold off until every owed verdict has come back
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (verdicts_pending != 0);
    @(posedge clk);
  endtask

  initial begin
    int pick;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed texts
    put_str("7");
    send_text();
    put_str("truex");
    send_text();
    put_str("[nul");
    send_text();
    text_q.push_back(8'h00);
    send_text();
    put_str("\"\\uA0f9");
    text_q.push_back(8'h00);
    text_q.push_back(8'hff);
    text_q.push_back("\"");
    send_text();
    put_str("{\"k\":[-1e5]}");
    send_text();
    text_q.push_back(8'hff);
    text_q.push_back("]");
    send_text();
    drain();

    // Random texts: mostly well-formed, some broken, deep or noise
    while (bytes_sent < BYTE_TARGET) begin
      pick = $urandom_range(0, 19);
      if (pick < 2) begin
        gen_deep();
      end else if (pick < 4) begin
        gen_noise();
      end else begin
        gen_document();
        if ($urandom_range(0, 3) == 0) corrupt();
      end
      send_text();
      if ($urandom_range(0, 7) == 0) drain();
    end

    drain();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && verdicts_pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/jsv_pkg.sv
rtl/json_syntax_validator.sv
test/json_syntax_validator_check.sv
test/json_syntax_validator_test.sv
